// ----- rtl/core/mtf_pkg.sv -----
// ----------------------------------------------------------------------------
// Minutia triangle features package
// Shared widths, constants and the arctangent table of the angle lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package mtf_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int ANGLE_BITS_DEF = 16;

    localparam int CORDIC_STEPS = 30;
    localparam int LANE_LAT     = CORDIC_STEPS + 2;
    localparam int XY_W         = 62;
    localparam int Z_W          = 34;

    localparam int MAX_SIZE_W = 11;
    localparam logic [MAX_SIZE_W-1:0] MAX_SIZE_RESET = 11'd690;

    localparam int QUAL_W     = 16;
    localparam int QSUM_W     = QUAL_W + 2;
    localparam int QPROD_W    = 2 * QSUM_W;
    localparam int QUAL_SHIFT = 19;
    localparam logic [QSUM_W-1:0] QUAL_RECIP = 18'd174763;
    localparam logic [QUAL_W-1:0] QUAL_LOW   = 16'd66;
    localparam logic [QUAL_W-1:0] QUAL_HIGH  = 16'd65470;

    localparam int SIDE_W    = 16;
    localparam int DIV_STEPS = SIDE_W;

    localparam logic signed [Z_W-1:0] Z_PI      = 34'sh0_8000_0000;
    localparam logic signed [Z_W-1:0] Z_HALF_PI = 34'sh0_4000_0000;

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
    };

endpackage

`default_nettype wire

// ----- rtl/core/minutia_triangle_features_unit.sv -----
// Throughput: one request per cycle; the pipeline holds while a result is stalled.
// The longest path runs through the square root and divider stages of the side unit.
// Reset clears the valid chain and loads max_size with 690; payload is not reset.
// ----------------------------------------------------------------------------
// Minutia triangle features unit
// Three angle lanes, a side unit and direction and quality logic feed one
// merged, aligned result per triangle.
// ----------------------------------------------------------------------------
`default_nettype none

module minutia_triangle_features_unit
    import mtf_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [MAX_SIZE_W-1:0]  i_cfg_data,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [COORD_BITS-1:0]  i_ax,
    input  wire logic [COORD_BITS-1:0]  i_ay,
    input  wire logic [COORD_BITS-1:0]  i_bx,
    input  wire logic [COORD_BITS-1:0]  i_by_coord,
    input  wire logic [COORD_BITS-1:0]  i_cx,
    input  wire logic [COORD_BITS-1:0]  i_cy,
    input  wire logic [ANGLE_BITS-1:0]  i_dir_a,
    input  wire logic [ANGLE_BITS-1:0]  i_dir_b,
    input  wire logic [ANGLE_BITS-1:0]  i_dir_c,
    input  wire logic [QUAL_W-1:0]      i_qual_a,
    input  wire logic [QUAL_W-1:0]      i_qual_b,
    input  wire logic [QUAL_W-1:0]      i_qual_c,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic      [ANGLE_BITS-1:0]  o_largest_angle,
    output logic      [ANGLE_BITS-1:0]  o_second_angle,
    output logic      [SIDE_W-1:0]      o_longest_side,
    output logic      [ANGLE_BITS-1:0]  o_largest_dir_diff,
    output logic      [ANGLE_BITS-1:0]  o_second_dir_diff,
    output logic      [QUAL_W-1:0]      o_mean_quality,
    output logic                        o_degenerate
);

    localparam int DFW      = COORD_BITS + 1;
    localparam int PW       = 2 * COORD_BITS + 2;
    localparam int SW       = 2 * COORD_BITS + 3;
    localparam int CR_W     = 2 * COORD_BITS + 1;
    localparam int L2W      = 2 * COORD_BITS + 1;
    localparam int RW       = COORD_BITS + 17;
    localparam int SIDE_LAT = 1 + RW + DIV_STEPS;
    localparam int ANG_DLY  = SIDE_LAT - LANE_LAT - 1;
    localparam int PIPE_N   = 3 + SIDE_LAT;
    localparam int MISC_W   = 1 + 2 * ANGLE_BITS + QUAL_W;

    localparam logic [ANGLE_BITS-1:0] ANG_PI  = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [ANGLE_BITS:0]   ANG_2PI = (ANGLE_BITS + 1)'(1) << ANGLE_BITS;

    function automatic logic [ANGLE_BITS-1:0] dir_diff(
        input logic [ANGLE_BITS-1:0] a,
        input logic [ANGLE_BITS-1:0] b
    );
        logic [ANGLE_BITS-1:0] d, dp, m;
        logic [ANGLE_BITS:0]   d2;
        d  = (a > b) ? a - b : b - a;
        dp = (d > ANG_PI) ? d - ANG_PI : ANG_PI - d;
        d2 = ANG_2PI - (ANGLE_BITS + 1)'(d);
        m  = (dp < d) ? dp : d;
        if (d2 < (ANGLE_BITS + 1)'(m)) begin
            m = d2[ANGLE_BITS-1:0];
        end
        return m;
    endfunction

    function automatic logic [ANGLE_BITS-1:0] umax(
        input logic [ANGLE_BITS-1:0] a,
        input logic [ANGLE_BITS-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    function automatic logic [ANGLE_BITS-1:0] umin(
        input logic [ANGLE_BITS-1:0] a,
        input logic [ANGLE_BITS-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    // Handshake and configuration.
    logic                  en;
    logic [PIPE_N-1:0]     r_v;
    logic [MAX_SIZE_W-1:0] r_max_size;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;
    assign o_valid = r_v[PIPE_N-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v        <= '0;
            r_max_size <= MAX_SIZE_RESET;
        end else begin
            if (en) begin
                r_v <= {r_v[PIPE_N-2:0], i_valid};
            end
            if (i_cfg_we) begin
                r_max_size <= i_cfg_data;
            end
        end
    end

    // Input registers.
    logic [COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic [ANGLE_BITS-1:0] r_da, r_db, r_dc;
    logic [QUAL_W-1:0]     r_qa, r_qb, r_qc;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax <= i_ax;
            r_ay <= i_ay;
            r_bx <= i_bx;
            r_by <= i_by_coord;
            r_cx <= i_cx;
            r_cy <= i_cy;
            r_da <= i_dir_a;
            r_db <= i_dir_b;
            r_dc <= i_dir_c;
            r_qa <= i_qual_a;
            r_qb <= i_qual_b;
            r_qc <= i_qual_c;
        end
    end

    // Edge vectors and products.
    logic signed [DFW-1:0] abx, aby, bcx, bcy, cax, cay;
    logic [QSUM_W-1:0]     qsum;

    always_comb begin
        abx  = $signed(DFW'(r_bx)) - $signed(DFW'(r_ax));
        aby  = $signed(DFW'(r_by)) - $signed(DFW'(r_ay));
        bcx  = $signed(DFW'(r_cx)) - $signed(DFW'(r_bx));
        bcy  = $signed(DFW'(r_cy)) - $signed(DFW'(r_by));
        cax  = $signed(DFW'(r_ax)) - $signed(DFW'(r_cx));
        cay  = $signed(DFW'(r_ay)) - $signed(DFW'(r_cy));
        qsum = QSUM_W'(r_qa) + QSUM_W'(r_qb) + QSUM_W'(r_qc);
    end

    logic signed [PW-1:0] r_pc1, r_pc2, r_pa1, r_pa2, r_pb1, r_pb2, r_pd1, r_pd2;
    logic signed [PW-1:0] r_sab1, r_sab2, r_sbc1, r_sbc2, r_sca1, r_sca2;
    logic [ANGLE_BITS-1:0] r_ddab, r_ddbc, r_ddca;
    logic [QPROD_W-1:0]    r_qprod;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pc1  <= abx * (-cay);
            r_pc2  <= aby * (-cax);
            r_pa1  <= abx * (-cax);
            r_pa2  <= aby * (-cay);
            r_pb1  <= bcx * (-abx);
            r_pb2  <= bcy * (-aby);
            r_pd1  <= cax * (-bcx);
            r_pd2  <= cay * (-bcy);
            r_sab1 <= abx * abx;
            r_sab2 <= aby * aby;
            r_sbc1 <= bcx * bcx;
            r_sbc2 <= bcy * bcy;
            r_sca1 <= cax * cax;
            r_sca2 <= cay * cay;
            r_ddab <= dir_diff(r_da, r_db);
            r_ddbc <= dir_diff(r_db, r_dc);
            r_ddca <= dir_diff(r_dc, r_da);
            r_qprod <= QPROD_W'(qsum) * QPROD_W'(QUAL_RECIP);
        end
    end

    // Sums, flags and clamps.
    logic signed [SW-1:0]  cross_sum;
    logic [QUAL_W-1:0]     q_mean;
    logic [QUAL_W:0]       q_raw;

    assign cross_sum = SW'(r_pc1) - SW'(r_pc2);
    assign q_raw = r_qprod[QUAL_SHIFT+QUAL_W:QUAL_SHIFT];

    always_comb begin
        priority if (q_raw < (QUAL_W + 1)'(QUAL_LOW)) begin
            q_mean = QUAL_LOW;
        end else if (q_raw > (QUAL_W + 1)'(QUAL_HIGH)) begin
            q_mean = QUAL_HIGH;
        end else begin
            q_mean = q_raw[QUAL_W-1:0];
        end
    end

    logic [CR_W-1:0]       r_cr;
    logic signed [SW-1:0]  r_dot_a, r_dot_b, r_dot_c;
    logic [L2W-1:0]        r_l2_ab, r_l2_bc, r_l2_ca;
    logic                  r_degen;
    logic [ANGLE_BITS-1:0] r_dd_hi, r_dd_mid;
    logic [QUAL_W-1:0]     r_qmean;
    logic signed [SW-1:0]  cross_abs;

    assign cross_abs = cross_sum[SW-1] ? -cross_sum : cross_sum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cr     <= cross_abs[CR_W-1:0];
            r_dot_a  <= SW'(r_pa1) + SW'(r_pa2);
            r_dot_b  <= SW'(r_pb1) + SW'(r_pb2);
            r_dot_c  <= SW'(r_pd1) + SW'(r_pd2);
            r_l2_ab  <= L2W'(r_sab1) + L2W'(r_sab2);
            r_l2_bc  <= L2W'(r_sbc1) + L2W'(r_sbc2);
            r_l2_ca  <= L2W'(r_sca1) + L2W'(r_sca2);
            r_degen  <= (cross_sum == '0);
            r_dd_hi  <= umax(umax(r_ddab, r_ddbc), umax(umax(r_ddbc, r_ddca),
                        umax(r_ddca, r_ddab)));
            r_dd_mid <= umin(umax(r_ddab, r_ddbc), umin(umax(r_ddbc, r_ddca),
                        umax(r_ddca, r_ddab)));
            r_qmean  <= q_mean;
        end
    end

    // Angle lanes and merge.
    logic [ANGLE_BITS-1:0] ang_a, ang_b, ang_c;
    logic [ANGLE_BITS-1:0] r_ang_hi, r_ang_mid;

    mtf_cordic_lane #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)) u_lane_a (
        .i_clk(i_clk), .i_en(en), .i_cr(r_cr), .i_dt(r_dot_a), .o_angle(ang_a)
    );

    mtf_cordic_lane #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)) u_lane_b (
        .i_clk(i_clk), .i_en(en), .i_cr(r_cr), .i_dt(r_dot_b), .o_angle(ang_b)
    );

    mtf_cordic_lane #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)) u_lane_c (
        .i_clk(i_clk), .i_en(en), .i_cr(r_cr), .i_dt(r_dot_c), .o_angle(ang_c)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang_hi  <= umax(umax(ang_a, ang_b), umax(umax(ang_b, ang_c),
                         umax(ang_c, ang_a)));
            r_ang_mid <= umin(umax(ang_a, ang_b), umin(umax(ang_b, ang_c),
                         umax(ang_c, ang_a)));
        end
    end

    logic [2*ANGLE_BITS-1:0] ang_d;

    mtf_delay #(.DEPTH(ANG_DLY), .WIDTH(2 * ANGLE_BITS)) u_ang_dly (
        .i_clk(i_clk), .i_en(en), .i_d({r_ang_hi, r_ang_mid}), .o_q(ang_d)
    );

    // Side unit.
    mtf_side_unit #(.COORD_BITS(COORD_BITS)) u_side (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_l2_ab    (r_l2_ab),
        .i_l2_bc    (r_l2_bc),
        .i_l2_ca    (r_l2_ca),
        .i_max_size (r_max_size),
        .o_side     (o_longest_side)
    );

    // Direction, quality and collinear flag alignment.
    logic [MISC_W-1:0] misc_d;

    mtf_delay #(.DEPTH(SIDE_LAT), .WIDTH(MISC_W)) u_misc_dly (
        .i_clk(i_clk), .i_en(en), .i_d({r_degen, r_dd_hi, r_dd_mid, r_qmean}),
        .o_q(misc_d)
    );

    assign o_degenerate       = misc_d[MISC_W-1];
    assign o_largest_dir_diff = misc_d[QUAL_W+2*ANGLE_BITS-1:QUAL_W+ANGLE_BITS];
    assign o_second_dir_diff  = misc_d[QUAL_W+ANGLE_BITS-1:QUAL_W];
    assign o_mean_quality     = misc_d[QUAL_W-1:0];
    assign o_largest_angle    = o_degenerate ? ANG_PI : ang_d[2*ANGLE_BITS-1:ANGLE_BITS];
    assign o_second_angle     = o_degenerate ? '0 : ang_d[ANGLE_BITS-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/mtf_delay.sv -----
// ----------------------------------------------------------------------------
// Minutia triangle features delay line
// Register chain that aligns a payload with the longest pipeline path.
// ----------------------------------------------------------------------------
`default_nettype none

module mtf_delay #(
    parameter int DEPTH = 1,
    parameter int WIDTH = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [WIDTH-1:0] i_d,
    output logic      [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

`default_nettype wire

// ----- rtl/core/mtf_cordic_lane.sv -----
// ----------------------------------------------------------------------------
// Minutia triangle features angle lane
// Pipelined vectoring rotator giving the interior angle at one vertex.
// ----------------------------------------------------------------------------
`default_nettype none

module mtf_cordic_lane
    import mtf_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic        [2*COORD_BITS:0]   i_cr,
    input  wire logic signed [2*COORD_BITS+2:0] i_dt,
    output logic             [ANGLE_BITS-1:0]   o_angle
);

    localparam int CR_W      = 2 * COORD_BITS + 1;
    localparam int DT_W      = 2 * COORD_BITS + 3;
    localparam int PRE_SHIFT = 57 - 2 * COORD_BITS;

    logic signed [XY_W-1:0] r_x [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] r_y [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  r_z [CORDIC_STEPS+1];
    logic        [ANGLE_BITS-1:0] r_angle;

    logic signed [XY_W-1:0] cr_e, dt_e, n_x0, n_y0;
    logic signed [Z_W-1:0]  n_z0;
    logic        [31:0]     z_clamp, z_round;

    always_comb begin
        cr_e = {{(XY_W-CR_W){1'b0}}, i_cr};
        dt_e = {{(XY_W-DT_W){i_dt[DT_W-1]}}, i_dt};
        if (i_dt[DT_W-1]) begin
            n_x0 = cr_e;
            n_y0 = -dt_e;
            n_z0 = Z_HALF_PI;
        end else begin
            n_x0 = dt_e;
            n_y0 = cr_e;
            n_z0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x0 <<< PRE_SHIFT;
            r_y[0] <= n_y0 <<< PRE_SHIFT;
            r_z[0] <= n_z0;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        logic signed [XY_W-1:0] xs, ys;
        logic signed [Z_W-1:0]  za;

        assign xs = r_x[k] >>> k;
        assign ys = r_y[k] >>> k;
        assign za = {2'b00, ATAN_TAB[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_y[k][XY_W-1]) begin
                    r_x[k+1] <= r_x[k] + ys;
                    r_y[k+1] <= r_y[k] - xs;
                    r_z[k+1] <= r_z[k] + za;
                end else begin
                    r_x[k+1] <= r_x[k] - ys;
                    r_y[k+1] <= r_y[k] + xs;
                    r_z[k+1] <= r_z[k] - za;
                end
            end
        end
    end

    always_comb begin
        priority if (r_z[CORDIC_STEPS][Z_W-1]) begin
            z_clamp = '0;
        end else if (r_z[CORDIC_STEPS] > Z_PI) begin
            z_clamp = Z_PI[31:0];
        end else begin
            z_clamp = r_z[CORDIC_STEPS][31:0];
        end
        z_round = z_clamp + (32'd1 << (31 - ANGLE_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= z_round[31:32-ANGLE_BITS];
        end
    end

    assign o_angle = r_angle;

endmodule

`default_nettype wire

// ----- rtl/core/mtf_side_unit.sv -----
// ----------------------------------------------------------------------------
// Minutia triangle features side unit
// Longest squared side, pipelined square root and division by the diagonal.
// ----------------------------------------------------------------------------
`default_nettype none

module mtf_side_unit
    import mtf_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic [2*COORD_BITS:0]   i_l2_ab,
    input  wire logic [2*COORD_BITS:0]   i_l2_bc,
    input  wire logic [2*COORD_BITS:0]   i_l2_ca,
    input  wire logic [MAX_SIZE_W-1:0]   i_max_size,
    output logic      [SIDE_W-1:0]       o_side
);

    localparam int L2W   = 2 * COORD_BITS + 1;
    localparam int RW    = COORD_BITS + 17;
    localparam int V_W   = 2 * RW;
    localparam int REM_W = RW + 2;
    localparam int DW    = RW + DIV_STEPS;
    localparam int MSQ_W = 2 * MAX_SIZE_W;
    localparam int CMP_W = L2W + MSQ_W;

    logic [L2W-1:0]   l2_max;
    logic [MSQ_W-1:0] msq;
    logic             n_sat;

    logic [V_W-1:0]   r_v    [RW+1];
    logic [REM_W-1:0] r_rem  [RW+1];
    logic [RW-1:0]    r_root [RW+1];
    logic             r_sat  [RW+1];

    logic [RW-1:0]        r_drem [DIV_STEPS];
    logic [SIDE_W-1:0]    r_q    [DIV_STEPS];
    logic                 r_dsat [DIV_STEPS];

    always_comb begin
        l2_max = i_l2_ab;
        if (i_l2_bc > l2_max) begin
            l2_max = i_l2_bc;
        end
        if (i_l2_ca > l2_max) begin
            l2_max = i_l2_ca;
        end
        msq   = MSQ_W'(i_max_size) * MSQ_W'(i_max_size);
        n_sat = CMP_W'(l2_max) >= CMP_W'(msq);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0]    <= V_W'({l2_max, 32'd0});
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_sat[0]  <= n_sat;
        end
    end

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        logic [REM_W-1:0] rem_sh, trial;
        logic             ge;

        assign rem_sh = {r_rem[k][REM_W-3:0], r_v[k][V_W-1 -: 2]};
        assign trial  = {r_root[k], 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[k+1]    <= r_v[k] << 2;
                r_rem[k+1]  <= ge ? rem_sh - trial : rem_sh;
                r_root[k+1] <= {r_root[k][RW-2:0], ge};
                r_sat[k+1]  <= r_sat[k];
            end
        end
    end

    for (genvar d = 0; d < DIV_STEPS; d++) begin : g_div
        logic [RW-1:0]     src_rem;
        logic [SIDE_W-1:0] src_q;
        logic              src_sat;
        logic [DW-1:0]     den;
        logic              ge;

        if (d == 0) begin : g_first
            assign src_rem = r_root[RW];
            assign src_q   = '0;
            assign src_sat = r_sat[RW];
        end else begin : g_next
            assign src_rem = r_drem[d-1];
            assign src_q   = r_q[d-1];
            assign src_sat = r_dsat[d-1];
        end

        assign den = DW'(i_max_size) << (DIV_STEPS - 1 - d);
        assign ge  = DW'(src_rem) >= den;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_drem[d] <= ge ? src_rem - den[RW-1:0] : src_rem;
                r_q[d]    <= {src_q[SIDE_W-2:0], ge};
                r_dsat[d] <= src_sat;
            end
        end
    end

    assign o_side = r_dsat[DIV_STEPS-1] ? '1 : r_q[DIV_STEPS-1];

endmodule

`default_nettype wire

// ----- verif/minutia_triangle_features_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minutia triangle features unit testbench
// Drives triangles of three minutiae through the unit and checks every
// feature result against an in-bench CORDIC/integer predictor. It steps the
// image diagonal through several values, including both extremes, and
// applies random idling on both the request and result sides.
// ----------------------------------------------------------------------------

module minutia_triangle_features_unit_tb;
    import mtf_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int AB = ANGLE_BITS_DEF;
    localparam longint ANG_PI = 64'd1 << (AB - 1);
    localparam int SETTLE = 60;
    localparam int WATCH_LIMIT = 4000;

    typedef struct packed {
        logic [CB-1:0] ax, ay, bx, by, cx, cy;
        logic [AB-1:0] da, db, dc;
        logic [QUAL_W-1:0] qa, qb, qc;
    } triangle_t;

    typedef struct packed {
        logic [AB-1:0] big_ang, mid_ang;
        logic [SIDE_W-1:0] side;
        logic [AB-1:0] big_dir, mid_dir;
        logic [QUAL_W-1:0] qual;
        logic degen;
    } features_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [MAX_SIZE_W-1:0] i_cfg_data;
    logic i_valid, o_stall, o_valid, i_stall;
    logic [CB-1:0] i_ax, i_ay, i_bx, i_by_coord, i_cx, i_cy;
    logic [AB-1:0] i_dir_a, i_dir_b, i_dir_c;
    logic [QUAL_W-1:0] i_qual_a, i_qual_b, i_qual_c;
    logic [AB-1:0] o_largest_angle, o_second_angle, o_largest_dir_diff, o_second_dir_diff;
    logic [SIDE_W-1:0] o_longest_side;
    logic [QUAL_W-1:0] o_mean_quality;
    logic o_degenerate;

    minutia_triangle_features_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_ax(i_ax), .i_ay(i_ay), .i_bx(i_bx), .i_by_coord(i_by_coord),
        .i_cx(i_cx), .i_cy(i_cy), .i_dir_a(i_dir_a), .i_dir_b(i_dir_b),
        .i_dir_c(i_dir_c), .i_qual_a(i_qual_a), .i_qual_b(i_qual_b),
        .i_qual_c(i_qual_c), .o_valid(o_valid), .i_stall(i_stall),
        .o_largest_angle(o_largest_angle), .o_second_angle(o_second_angle),
        .o_longest_side(o_longest_side), .o_largest_dir_diff(o_largest_dir_diff),
        .o_second_dir_diff(o_second_dir_diff), .o_mean_quality(o_mean_quality),
        .o_degenerate(o_degenerate)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    triangle_t pending_tris[$];
    features_t expected_feats[$];
    triangle_t cur_tri;
    logic [MAX_SIZE_W-1:0] diag_px;
    int unsigned cycle_cnt;
    int errors;
    int idle_cnt;
    bit quiet;

    assign quiet = (cycle_cnt > 800 && cycle_cnt < 1400);

    function automatic longint unsigned interior_angle(longint cr, longint dt);
        longint x, y, z, nx;
        longint unsigned r;
        if (dt < 0) begin
            x = cr; y = -dt; z = Z_HALF_PI;
        end else begin
            x = dt; y = cr; z = 0;
        end
        x = x <<< (57 - 2 * CB);
        y = y <<< (57 - 2 * CB);
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += longint'(ATAN_TAB[i]);
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= longint'(ATAN_TAB[i]);
            end
            x = nx;
        end
        if (z < 0) z = 0;
        if (z > Z_PI) z = Z_PI;
        r = (longint'(z) + (64'd1 << (31 - AB))) >> (32 - AB);
        if (r > ANG_PI) r = ANG_PI;
        return r;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res, bits;
        res = 0;
        bits = 64'd1 << 62;
        while (bits > v) bits >>= 2;
        while (bits != 0) begin
            if (v >= res + bits) begin
                v -= res + bits;
                res = (res >> 1) + bits;
            end else begin
                res >>= 1;
            end
            bits >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned dir_gap(longint unsigned a, longint unsigned b);
        longint unsigned d, dp, d2, m;
        d = a > b ? a - b : b - a;
        dp = d > ANG_PI ? d - ANG_PI : ANG_PI - d;
        d2 = 2 * ANG_PI - d;
        m = d < dp ? d : dp;
        return m < d2 ? m : d2;
    endfunction

    function automatic void rank_two(input longint unsigned a, b, c,
                                     output longint unsigned hi, mid);
        longint unsigned ab, bc, ca;
        ab = a > b ? a : b;
        bc = b > c ? b : c;
        ca = c > a ? c : a;
        hi = ab > bc ? ab : bc;
        hi = hi > ca ? hi : ca;
        mid = ab < bc ? ab : bc;
        mid = mid < ca ? mid : ca;
    endfunction

    function automatic features_t triangle_features(triangle_t t, logic [MAX_SIZE_W-1:0] diag);
        features_t f;
        longint abx, aby, bcx, bcy, cax, cay, cr, acr;
        longint unsigned hi, mid, l2, s, q, la, lb, lc;
        abx = longint'(t.bx) - longint'(t.ax);
        aby = longint'(t.by) - longint'(t.ay);
        bcx = longint'(t.cx) - longint'(t.bx);
        bcy = longint'(t.cy) - longint'(t.by);
        cax = longint'(t.ax) - longint'(t.cx);
        cay = longint'(t.ay) - longint'(t.cy);
        cr = abx * (-cay) - aby * (-cax);
        f.degen = (cr == 0);
        if (f.degen) begin
            hi = ANG_PI;
            mid = 0;
        end else begin
            acr = cr < 0 ? -cr : cr;
            rank_two(interior_angle(acr, abx * (-cax) + aby * (-cay)),
                     interior_angle(acr, bcx * (-abx) + bcy * (-aby)),
                     interior_angle(acr, cax * (-bcx) + cay * (-bcy)), hi, mid);
        end
        f.big_ang = hi[AB-1:0];
        f.mid_ang = mid[AB-1:0];
        la = abx * abx + aby * aby;
        lb = bcx * bcx + bcy * bcy;
        lc = cax * cax + cay * cay;
        l2 = la > lb ? la : lb;
        l2 = l2 > lc ? l2 : lc;
        if (l2 >= longint'(diag) * longint'(diag)) begin
            s = 65535;
        end else begin
            s = root_floor(l2 << 32) / longint'(diag);
            if (s > 65535) s = 65535;
        end
        f.side = s[15:0];
        rank_two(dir_gap(t.da, t.db), dir_gap(t.db, t.dc), dir_gap(t.dc, t.da), hi, mid);
        f.big_dir = hi[AB-1:0];
        f.mid_dir = mid[AB-1:0];
        q = (longint'(t.qa) + longint'(t.qb) + longint'(t.qc)) / 3;
        if (q < QUAL_LOW) q = QUAL_LOW;
        if (q > QUAL_HIGH) q = QUAL_HIGH;
        f.qual = q[15:0];
        return f;
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                expected_feats.push_back(triangle_features(cur_tri, diag_px));
            if (!i_valid || !o_stall) begin
                if (pending_tris.size() > 0 && (quiet || $urandom_range(99) >= 7)) begin
                    cur_tri = pending_tris.pop_front();
                    i_valid <= 1'b1;
                    i_ax <= cur_tri.ax; i_ay <= cur_tri.ay;
                    i_bx <= cur_tri.bx; i_by_coord <= cur_tri.by;
                    i_cx <= cur_tri.cx; i_cy <= cur_tri.cy;
                    i_dir_a <= cur_tri.da; i_dir_b <= cur_tri.db; i_dir_c <= cur_tri.dc;
                    i_qual_a <= cur_tri.qa; i_qual_b <= cur_tri.qb; i_qual_c <= cur_tri.qc;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        features_t got, want;
        if (i_rst_n) begin
            i_stall <= !quiet && ($urandom_range(99) < 7);
            if (o_valid && !i_stall) begin
                got = '{o_largest_angle, o_second_angle, o_longest_side,
                        o_largest_dir_diff, o_second_dir_diff, o_mean_quality,
                        o_degenerate};
                if (expected_feats.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %p", got);
                end else begin
                    want = expected_feats.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cnt <= 0;
            else
                idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= WATCH_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic triangle_t rand_triangle();
        triangle_t t;
        int span, k;
        span = ($urandom_range(3) == 0) ? 15 : 1023;
        t.ax = CB'($urandom_range(span)); t.ay = CB'($urandom_range(span));
        t.bx = CB'($urandom_range(span)); t.by = CB'($urandom_range(span));
        t.cx = CB'($urandom_range(span)); t.cy = CB'($urandom_range(span));
        k = $urandom_range(9);
        if (k == 0) begin
            t.cx = t.ax; t.bx = t.ax;
        end else if (k == 1) begin
            t.cy = t.by;
            t.ay = t.by;
        end else if (k == 2) begin
            t.cx = t.bx; t.cy = t.by;
        end
        t.da = AB'($urandom); t.db = AB'($urandom); t.dc = AB'($urandom);
        t.qa = QUAL_W'($urandom); t.qb = QUAL_W'($urandom); t.qc = QUAL_W'($urandom);
        return t;
    endfunction

    task automatic add_tri(int ax, ay, bx, by, cx, cy, da, db, dc, qa, qb, qc);
        triangle_t t;
        t = '{CB'(ax), CB'(ay), CB'(bx), CB'(by), CB'(cx), CB'(cy),
              AB'(da), AB'(db), AB'(dc), QUAL_W'(qa), QUAL_W'(qb), QUAL_W'(qc)};
        pending_tris.push_back(t);
    endtask

    task automatic drain();
        while (pending_tris.size() > 0 || i_valid || expected_feats.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_diagonal(logic [MAX_SIZE_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        diag_px = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [MAX_SIZE_W-1:0] diags[5];
        cycle_cnt = 0;
        errors = 0;
        idle_cnt = 0;
        diag_px = MAX_SIZE_RESET;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_stall <= 1'b0;
        {i_ax, i_ay, i_bx, i_by_coord, i_cx, i_cy} <= '0;
        {i_dir_a, i_dir_b, i_dir_c, i_qual_a, i_qual_b, i_qual_c} <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_tri(1023, 1023, 1023, 1023, 1023, 1023, 65535, 65535, 65535,
                65535, 65535, 65535);
        add_tri(0, 0, 1023, 0, 0, 1023, 0, 32768, 65535, 65535, 0, 0);
        add_tri(0, 0, 1023, 1023, 1023, 0, 16384, 49152, 32767, 100, 50, 20);
        add_tri(0, 0, 500, 500, 1000, 1000, 1, 32769, 65534, 65535, 65535, 65534);
        add_tri(0, 0, 1023, 1022, 1022, 1021, 0, 16384, 32768, 30000, 30000, 30000);
        add_tri(10, 10, 20, 10, 15, 1000, 100, 200, 300, 200, 0, 0);
        add_tri(1023, 0, 0, 1023, 1, 1, 65535, 0, 32768, 0, 65535, 0);
        add_tri(5, 5, 6, 5, 5, 6, 43690, 21845, 0, 1, 2, 3);
        add_tri(0, 512, 1023, 512, 511, 513, 8192, 57344, 40960, 43690, 43690, 43691);
        add_tri(3, 4, 3, 4, 900, 100, 32768, 32768, 0, 65535, 65535, 0);
        add_tri(100, 200, 300, 400, 100, 200, 0, 1, 2, 12345, 54321, 999);
        foreach (diags[i]) begin
            repeat (240) pending_tris.push_back(rand_triangle());
            drain();
            if (i == 0) diags[1] = 11'd1;
            if (i == 1) diags[2] = 11'd2047;
            if (i == 2) diags[3] = MAX_SIZE_W'($urandom_range(2047, 1));
            if (i == 3) diags[4] = 11'd1448;
            if (i < 4) set_diagonal(diags[i + 1]);
        end
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/mtf_pkg.sv
rtl/core/mtf_delay.sv
rtl/core/mtf_cordic_lane.sv
rtl/core/mtf_side_unit.sv
rtl/core/minutia_triangle_features_unit.sv
verif/minutia_triangle_features_unit_tb.sv
